>>> hw/rtl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and constants of the I2C register read master
// Payload structs of the tick and result channels, line phase codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRETCH_LIMIT  = 2'd1;

  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h15;
  localparam logic [16:0] STRETCH_LIMIT_RST  = 17'd100000;

  // line phases of the bus sequencer
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_SCL  = 5'd1,
    PH_ST_REL  = 5'd2,
    PH_ST_WAIT = 5'd3,
    PH_WB_SDA  = 5'd4,
    PH_WB_SCLH = 5'd5,
    PH_WB_WAIT = 5'd6,
    PH_AK_REL  = 5'd7,
    PH_AK_SCLH = 5'd8,
    PH_AK_WAIT = 5'd9,
    PH_RB_SCLH = 5'd10,
    PH_RB_WAIT = 5'd11,
    PH_MA_SDA  = 5'd12,
    PH_MA_SCLH = 5'd13,
    PH_MA_WAIT = 5'd14,
    PH_MA_REL  = 5'd15,
    PH_SP_SDA  = 5'd16,
    PH_SP_SCLH = 5'd17,
    PH_SP_WAIT = 5'd18
  } phase_e;

  // one tick
  typedef struct packed {
    logic       command;
    logic [7:0] reg_address;
    logic [7:0] byte_count;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  // one result
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       nack_seen;
  } out_item_t;

  // configuration write
  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage

>>> hw/rtl/i2crm_stream_if.sv
// ----------------------------------------------------------------------------
// i2crm_stream_if: valid/ready channels of the I2C register read master
// i2crm_in_if carries ticks, i2crm_out_if carries results.
// ----------------------------------------------------------------------------
interface i2crm_in_if;
  import i2crm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2crm_out_if;
  import i2crm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/i2crm_core.sv
// ----------------------------------------------------------------------------
// i2crm_core: bus sequencer of the I2C register read master
// Holds configuration and sequencer state; each accepted tick advances by at
// most one line phase and yields one result.
// ----------------------------------------------------------------------------
module i2crm_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2crm_pkg::cfg_wr_t   cfg_i,
  input  logic                 step_i,
  input  i2crm_pkg::in_item_t  item_i,
  output i2crm_pkg::out_item_t res_o
);
  import i2crm_pkg::*;

  // transaction segments
  localparam logic [1:0] SegDevWr  = 2'd0;
  localparam logic [1:0] SegRegAdr = 2'd1;
  localparam logic [1:0] SegDevRd  = 2'd2;
  localparam logic [1:0] SegData   = 2'd3;

  logic [6:0]  dev_addr_q;
  logic [16:0] stretch_limit_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  held_reg_q, held_reg_d;
  logic        bus_started_q, bus_started_d;
  logic [16:0] stretch_q, stretch_d;
  logic        nack_q, nack_d;
  logic [1:0]  segment_q, segment_d;
  logic        drv_scl_q, drv_scl_d;
  logic        drv_sda_q, drv_sda_d;

  logic [16:0] stretch_inc;
  logic        wait_done;
  logic [16:0] stretch_wait;
  logic [3:0]  bit_next;
  logic [7:0]  bytes_dec;
  logic        rd_valid;
  logic        rd_last;
  logic [7:0]  rd_byte;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q      <= DEVICE_ADDRESS_RST;
      stretch_limit_q <= STRETCH_LIMIT_RST;
    end else if (cfg_i.we) begin
      if (cfg_i.index == CFG_DEVICE_ADDRESS) begin
        dev_addr_q <= cfg_i.wdata[6:0];
      end else if (cfg_i.index == CFG_STRETCH_LIMIT) begin
        stretch_limit_q <= cfg_i.wdata;
      end
    end
  end

  // SCL-high wait: ends on SCL high or when the stretch limit runs out
  assign stretch_inc  = stretch_q + 17'd1;
  assign wait_done    = item_i.scl_in || (stretch_inc >= stretch_limit_q);
  assign stretch_wait = wait_done ? 17'd0 : stretch_inc;
  assign bit_next     = bit_index_q + 4'd1;
  assign bytes_dec    = bytes_left_q - 8'd1;

  // next state for one tick
  always_comb begin
    phase_d       = phase_q;
    bit_index_d   = bit_index_q;
    shift_d       = shift_q;
    bytes_left_d  = bytes_left_q;
    held_reg_d    = held_reg_q;
    bus_started_d = bus_started_q;
    stretch_d     = stretch_q;
    nack_d        = nack_q;
    segment_d     = segment_q;
    drv_scl_d     = drv_scl_q;
    drv_sda_d     = drv_sda_q;
    rd_valid      = 1'b0;
    rd_last       = 1'b0;
    rd_byte       = 8'd0;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (item_i.command) begin
            held_reg_d   = item_i.reg_address;
            bytes_left_d = item_i.byte_count;
            nack_d       = 1'b0;
            segment_d    = SegDevWr;
            stretch_d    = 17'd0;
            if (bus_started_q) begin
              phase_d = PH_ST_REL;
            end else begin
              drv_sda_d = 1'b1;
              phase_d   = PH_ST_SCL;
            end
          end
        end
        PH_ST_REL: begin
          drv_sda_d = 1'b0;
          drv_scl_d = 1'b0;
          phase_d   = PH_ST_WAIT;
        end
        PH_ST_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            drv_sda_d = 1'b1;
            phase_d   = PH_ST_SCL;
          end
        end
        PH_ST_SCL: begin
          drv_scl_d     = 1'b1;
          bus_started_d = 1'b1;
          shift_d       = {dev_addr_q, (segment_q == SegDevRd)};
          bit_index_d   = 4'd0;
          phase_d       = PH_WB_SDA;
        end
        PH_WB_SDA: begin
          drv_sda_d = ~shift_q[7];
          phase_d   = PH_WB_SCLH;
        end
        PH_WB_SCLH: begin
          drv_scl_d = 1'b0;
          phase_d   = PH_WB_WAIT;
        end
        PH_WB_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            drv_scl_d   = 1'b1;
            shift_d     = {shift_q[6:0], 1'b0};
            bit_index_d = bit_next;
            phase_d     = bit_next[3] ? PH_AK_REL : PH_WB_SDA;
          end
        end
        PH_AK_REL: begin
          drv_sda_d = 1'b0;
          phase_d   = PH_AK_SCLH;
        end
        PH_AK_SCLH: begin
          drv_scl_d = 1'b0;
          phase_d   = PH_AK_WAIT;
        end
        PH_AK_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            if (item_i.sda_in) begin
              nack_d = 1'b1;
            end
            drv_scl_d = 1'b1;
            // move on to the next segment of the transaction
            if (segment_q == SegDevWr) begin
              segment_d   = SegRegAdr;
              shift_d     = held_reg_q;
              bit_index_d = 4'd0;
              phase_d     = PH_WB_SDA;
            end else if (segment_q == SegRegAdr) begin
              segment_d = SegDevRd;
              phase_d   = PH_ST_REL;
            end else begin
              segment_d   = SegData;
              bit_index_d = 4'd0;
              shift_d     = 8'd0;
              phase_d     = (bytes_left_q == 8'd0) ? PH_SP_SDA : PH_RB_SCLH;
            end
          end
        end
        PH_RB_SCLH: begin
          drv_sda_d = 1'b0;
          drv_scl_d = 1'b0;
          phase_d   = PH_RB_WAIT;
        end
        PH_RB_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            shift_d     = {shift_q[6:0], item_i.sda_in};
            drv_scl_d   = 1'b1;
            bit_index_d = bit_next;
            if (bit_next[3]) begin
              rd_valid = 1'b1;
              rd_byte  = {shift_q[6:0], item_i.sda_in};
              rd_last  = (bytes_left_q == 8'd1);
              phase_d  = PH_MA_SDA;
            end else begin
              phase_d = PH_RB_SCLH;
            end
          end
        end
        PH_MA_SDA: begin
          // ACK all bytes but the last, which gets NACK
          drv_sda_d = (bytes_left_q != 8'd1);
          phase_d   = PH_MA_SCLH;
        end
        PH_MA_SCLH: begin
          drv_scl_d = 1'b0;
          phase_d   = PH_MA_WAIT;
        end
        PH_MA_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            drv_scl_d    = 1'b1;
            bytes_left_d = bytes_dec;
            phase_d      = (bytes_dec == 8'd0) ? PH_SP_SDA : PH_MA_REL;
          end
        end
        PH_MA_REL: begin
          drv_sda_d   = 1'b0;
          bit_index_d = 4'd0;
          shift_d     = 8'd0;
          phase_d     = PH_RB_SCLH;
        end
        PH_SP_SDA: begin
          drv_sda_d = 1'b1;
          phase_d   = PH_SP_SCLH;
        end
        PH_SP_SCLH: begin
          drv_scl_d = 1'b0;
          phase_d   = PH_SP_WAIT;
        end
        PH_SP_WAIT: begin
          stretch_d = stretch_wait;
          if (wait_done) begin
            drv_sda_d     = 1'b0;
            drv_scl_d     = 1'b0;
            bus_started_d = 1'b0;
            phase_d       = PH_IDLE;
          end
        end
        default: begin
          drv_sda_d = 1'b0;
          drv_scl_d = 1'b0;
          phase_d   = PH_IDLE;
        end
      endcase
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl_drive_low = drv_scl_d;
    res_o.sda_drive_low = drv_sda_d;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.read_valid    = rd_valid;
    res_o.read_byte     = rd_byte;
    res_o.last_byte     = rd_last;
    res_o.nack_seen     = nack_d;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_index_q   <= 4'd0;
      shift_q       <= 8'd0;
      bytes_left_q  <= 8'd0;
      held_reg_q    <= 8'd0;
      bus_started_q <= 1'b0;
      stretch_q     <= 17'd0;
      nack_q        <= 1'b0;
      segment_q     <= SegDevWr;
      drv_scl_q     <= 1'b0;
      drv_sda_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      bit_index_q   <= bit_index_d;
      shift_q       <= shift_d;
      bytes_left_q  <= bytes_left_d;
      held_reg_q    <= held_reg_d;
      bus_started_q <= bus_started_d;
      stretch_q     <= stretch_d;
      nack_q        <= nack_d;
      segment_q     <= segment_d;
      drv_scl_q     <= drv_scl_d;
      drv_sda_q     <= drv_sda_d;
    end
  end

endmodule

>>> hw/rtl/i2crm_out_buf.sv
// ----------------------------------------------------------------------------
// i2crm_out_buf: result register with skid stage
// Holds up to two results so a new tick is taken while a result waits.
// ----------------------------------------------------------------------------
module i2crm_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  i2crm_pkg::out_item_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output i2crm_pkg::out_item_t data_o
);
  import i2crm_pkg::*;

  logic      out_valid_q;
  out_item_t out_data_q;
  logic      skid_valid_q;
  out_item_t skid_data_q;
  logic      pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= data_i;
      end else begin
        out_data_q <= data_i;
      end
    end
  end

endmodule

>>> hw/rtl/i2c_register_read_master_top.sv
// ----------------------------------------------------------------------------
// i2c_register_read_master_top: open-drain I2C master for register reads
// Top level: sequencer core plus result buffer on valid/ready channels.
// ----------------------------------------------------------------------------
// Each tick transaction on in_i samples SCL and SDA and advances the bus
// sequence by at most one line phase; it yields exactly one result on out_o.
// A tick is accepted every cycle while the skid entry is free: the sequencer
// step is one pass of logic between the state registers and the result
// register, and a two-entry result buffer (register plus skid) lets ticks
// keep flowing while a result waits. in_i.ready drops only when both entries
// are full. A start command given while busy is taken as a plain tick.
// Configuration writes are registered and belong to idle time.
module i2c_register_read_master_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [i2crm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [i2crm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  i2crm_in_if.sink                        in_i,
  i2crm_out_if.source                     out_o
);
  import i2crm_pkg::*;

  cfg_wr_t   cfg;
  out_item_t res;
  logic      buf_ready;
  logic      accept;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.wdata = cfg_wdata_i;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  i2crm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (accept),
    .item_i (in_i.payload),
    .res_o  (res)
  );

  i2crm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.payload)
  );

endmodule

>>> hw/rtl/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker: port-level assertions of the I2C register read master
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
module i2crm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input i2crm_pkg::out_item_t out_data_i
);
  import i2crm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  // every accepted tick leaves a result offered in the next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("tick transaction produced no result");

  // a completed byte only comes mid-transaction
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.read_valid) |-> out_data_i.busy_res)
    else $error("read byte outside a transaction");

  // last flag only comes with a byte
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.last_byte) |-> out_data_i.read_valid)
    else $error("last_byte without read_valid");

  // no byte, no data
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_i.read_valid) |-> (out_data_i.read_byte == 8'd0))
    else $error("read_byte set without read_valid");

endmodule

bind i2c_register_read_master_top i2crm_checker u_i2crm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the I2C register read master
// Ticks carrying sampled SCL/SDA levels and read commands are queued from
// planned bus reads and driven on in_i. A tick-level model of the master
// predicts one result per accepted tick, and each result seen on out_o is
// checked against it field by field. The run steps through several
// settings of device address and clock-stretch limit, with random idling
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import i2crm_pkg::*;

  localparam int TIMEOUT_NS      = 5_000_000;
  localparam int TICKS_PER_PHASE = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int CMD_BUSY_PCT    = 3;

  // indexes past the register list, writes there must do nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  // which byte of the bus read the sequencer is working on
  localparam logic [1:0] SEG_DEV_WR = 2'd0;
  localparam logic [1:0] SEG_REG    = 2'd1;
  localparam logic [1:0] SEG_DEV_RD = 2'd2;
  localparam logic [1:0] SEG_DATA   = 2'd3;

  // master state plus its configuration
  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [16:0] stretch_lim;
    phase_e      ph;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  bytes_left;
    logic [7:0]  reg_addr;
    logic        bus_on;
    logic [16:0] stretch_cnt;
    logic        nack;
    logic [1:0]  seg;
    logic        scl_lo;
    logic        sda_lo;
  } i2c_model_t;

  localparam i2c_model_t MODEL_RST = '{
    dev_addr: DEVICE_ADDRESS_RST, stretch_lim: STRETCH_LIMIT_RST, ph: PH_IDLE,
    bit_idx: 4'd0, shreg: 8'd0, bytes_left: 8'd0, reg_addr: 8'd0, bus_on: 1'b0,
    stretch_cnt: 17'd0, nack: 1'b0, seg: SEG_DEV_WR, scl_lo: 1'b0, sda_lo: 1'b0
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic      tick_valid = 1'b0;
  in_item_t  tick_data  = '0;
  logic      res_ready  = 1'b0;
  in_item_t  next_tick;

  i2crm_in_if  in_if ();
  i2crm_out_if out_if ();

  assign in_if.valid   = tick_valid;
  assign in_if.payload = tick_data;
  assign out_if.ready  = res_ready;

  i2c_register_read_master_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  in_item_t   pending_ticks[$];
  out_item_t  results_due[$];
  i2c_model_t plan_state;   // runs ahead while ticks are planned
  i2c_model_t pred_state;   // follows accepted ticks
  out_item_t  want;
  out_item_t  want_new;
  int         mismatches   = 0;
  int         results_seen = 0;

  // traffic profile of the current phase
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int scl_low_pct   = 0;
  int burst_pct     = 0;
  int burst_left    = 0;
  bit stall_phase   = 1'b0;
  int hold_left;
  bit hold_done;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // {done, next count} of one tick spent waiting for SCL high
  function automatic logic [17:0] stretch_next(input logic [16:0] cnt,
                                               input logic [16:0] lim,
                                               input logic        scl_high);
    logic [16:0] n;
    if (scl_high) return {1'b1, 17'd0};
    n = cnt + 17'd1;
    if (n >= lim) return {1'b1, 17'd0};
    return {1'b0, n};
  endfunction

  task automatic set_reg(inout i2c_model_t m, input logic [CfgIdxW-1:0] idx,
                         input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_DEVICE_ADDRESS: m.dev_addr = data[6:0];
      CFG_STRETCH_LIMIT:  m.stretch_lim = data;
      default: ;
    endcase
  endtask

  // one tick of the master: sample lines, take one line action
  task automatic master_tick(inout i2c_model_t m, input in_item_t t, output out_item_t r);
    logic [17:0] w;
    logic        wdone;
    w = stretch_next(m.stretch_cnt, m.stretch_lim, t.scl_in);
    wdone = w[17];
    r = '0;
    case (m.ph)
      PH_IDLE: begin
        if (t.command) begin
          m.reg_addr = t.reg_address;
          m.bytes_left = t.byte_count;
          m.nack = 1'b0;
          m.seg = SEG_DEV_WR;
          m.stretch_cnt = 17'd0;
          if (m.bus_on) begin
            m.ph = PH_ST_REL;
          end else begin
            m.sda_lo = 1'b1;
            m.ph = PH_ST_SCL;
          end
        end
      end
      PH_ST_REL: begin
        m.sda_lo = 1'b0;
        m.scl_lo = 1'b0;
        m.ph = PH_ST_WAIT;
      end
      PH_ST_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          m.sda_lo = 1'b1;
          m.ph = PH_ST_SCL;
        end
      end
      PH_ST_SCL: begin
        m.scl_lo = 1'b1;
        m.bus_on = 1'b1;
        m.shreg = {m.dev_addr, m.seg == SEG_DEV_RD};
        m.bit_idx = 4'd0;
        m.ph = PH_WB_SDA;
      end
      PH_WB_SDA: begin
        m.sda_lo = ~m.shreg[7];
        m.ph = PH_WB_SCLH;
      end
      PH_WB_SCLH: begin
        m.scl_lo = 1'b0;
        m.ph = PH_WB_WAIT;
      end
      PH_WB_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          m.scl_lo = 1'b1;
          m.shreg = {m.shreg[6:0], 1'b0};
          m.bit_idx = m.bit_idx + 4'd1;
          m.ph = (m.bit_idx >= 4'd8) ? PH_AK_REL : PH_WB_SDA;
        end
      end
      PH_AK_REL: begin
        m.sda_lo = 1'b0;
        m.ph = PH_AK_SCLH;
      end
      PH_AK_SCLH: begin
        m.scl_lo = 1'b0;
        m.ph = PH_AK_WAIT;
      end
      PH_AK_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          if (t.sda_in) m.nack = 1'b1;
          m.scl_lo = 1'b1;
          // device address, then register, then repeated start and read
          case (m.seg)
            SEG_DEV_WR: begin
              m.seg = SEG_REG;
              m.shreg = m.reg_addr;
              m.bit_idx = 4'd0;
              m.ph = PH_WB_SDA;
            end
            SEG_REG: begin
              m.seg = SEG_DEV_RD;
              m.ph = PH_ST_REL;
            end
            default: begin
              m.seg = SEG_DATA;
              m.bit_idx = 4'd0;
              m.shreg = 8'd0;
              m.ph = (m.bytes_left == 8'd0) ? PH_SP_SDA : PH_RB_SCLH;
            end
          endcase
        end
      end
      PH_RB_SCLH: begin
        m.sda_lo = 1'b0;
        m.scl_lo = 1'b0;
        m.ph = PH_RB_WAIT;
      end
      PH_RB_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          m.shreg = {m.shreg[6:0], t.sda_in};
          m.scl_lo = 1'b1;
          m.bit_idx = m.bit_idx + 4'd1;
          if (m.bit_idx >= 4'd8) begin
            r.read_valid = 1'b1;
            r.read_byte = m.shreg;
            r.last_byte = (m.bytes_left == 8'd1);
            m.ph = PH_MA_SDA;
          end else begin
            m.ph = PH_RB_SCLH;
          end
        end
      end
      PH_MA_SDA: begin
        // ACK all but the last byte
        m.sda_lo = (m.bytes_left != 8'd1);
        m.ph = PH_MA_SCLH;
      end
      PH_MA_SCLH: begin
        m.scl_lo = 1'b0;
        m.ph = PH_MA_WAIT;
      end
      PH_MA_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          m.scl_lo = 1'b1;
          m.bytes_left = m.bytes_left - 8'd1;
          m.ph = (m.bytes_left == 8'd0) ? PH_SP_SDA : PH_MA_REL;
        end
      end
      PH_MA_REL: begin
        m.sda_lo = 1'b0;
        m.bit_idx = 4'd0;
        m.shreg = 8'd0;
        m.ph = PH_RB_SCLH;
      end
      PH_SP_SDA: begin
        m.sda_lo = 1'b1;
        m.ph = PH_SP_SCLH;
      end
      PH_SP_SCLH: begin
        m.scl_lo = 1'b0;
        m.ph = PH_SP_WAIT;
      end
      PH_SP_WAIT: begin
        m.stretch_cnt = w[16:0];
        if (wdone) begin
          m.sda_lo = 1'b0;
          m.scl_lo = 1'b0;
          m.bus_on = 1'b0;
          m.ph = PH_IDLE;
        end
      end
      default: begin
        m.sda_lo = 1'b0;
        m.scl_lo = 1'b0;
        m.ph = PH_IDLE;
      end
    endcase
    r.scl_drive_low = m.scl_lo;
    r.sda_drive_low = m.sda_lo;
    r.busy_res = (m.ph != PH_IDLE);
    r.nack_seen = m.nack;
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] exp_val);
    $display("[%0t] result %0d: %s got %0h, want %0h", $realtime, results_seen, what,
             got, exp_val);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------
  // line levels: random lows, and bursts of low SCL that can outlast the stretch limit
  task automatic draw_lines(output logic scl, output logic sda);
    if (burst_left > 0) begin
      burst_left--;
      scl = 1'b0;
    end else if (plan_state.stretch_lim <= 17'd64 && $urandom_range(99) < burst_pct) begin
      burst_left = $urandom_range(int'(plan_state.stretch_lim) + 2, 1);
      scl = 1'b0;
    end else begin
      scl = ($urandom_range(99) >= scl_low_pct);
    end
    sda = 1'($urandom_range(1));
  endtask

  task automatic push_tick(input logic cmd, input logic [7:0] ra, input logic [7:0] bc,
                           input logic scl, input logic sda);
    in_item_t  t;
    out_item_t ignored;
    t.command = cmd;
    t.reg_address = ra;
    t.byte_count = bc;
    t.scl_in = scl;
    t.sda_in = sda;
    master_tick(plan_state, t, ignored);
    pending_ticks.push_back(t);
  endtask

  // ticks while the master is idle, with random fields and no command
  task automatic queue_idle(input int n);
    logic scl, sda;
    repeat (n) begin
      draw_lines(scl, sda);
      push_tick(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)), scl, sda);
    end
  endtask

  // one whole bus read: start command, then ticks until the master is idle
  task automatic queue_read(input logic [7:0] ra, input logic [7:0] cnt, output int n);
    logic scl, sda;
    draw_lines(scl, sda);
    push_tick(1'b1, ra, cnt, scl, sda);
    n = 1;
    while (plan_state.ph != PH_IDLE) begin
      draw_lines(scl, sda);
      // a stray command now and then, ignored while busy
      push_tick($urandom_range(99) < CMD_BUSY_PCT, 8'($urandom_range(255)),
                8'($urandom_range(255)), scl, sda);
      n++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || tick_valid || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    set_reg(plan_state, idx, data);
    set_reg(pred_state, idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_profile(input int src, input int sink, input int scl_lo,
                             input int burst, input bit stall);
    @(negedge clk_i);
    src_idle_pct = src;
    sink_idle_pct = sink;
    scl_low_pct = scl_lo;
    burst_pct = burst;
    burst_left = 0;
    stall_phase = stall;
  endtask

  task automatic run_random(input int src, input int sink, input int scl_lo,
                            input int burst, input bit stall);
    int         n;
    int         total;
    logic [7:0] cnt;
    set_profile(src, sink, scl_lo, burst, stall);
    total = 0;
    while (total < TICKS_PER_PHASE) begin
      queue_idle($urandom_range(3));
      cnt = ($urandom_range(99) < 85) ? 8'($urandom_range(2)) : 8'($urandom_range(5, 3));
      queue_read(8'($urandom_range(255)), cnt, n);
      total += n;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // tick driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid <= 1'b0;
      tick_data <= '0;
    end else if (!tick_valid || in_if.ready) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        tick_data <= next_tick;
        tick_valid <= 1'b1;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // result ready: random stalls, one long hold-off in the pressure phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (!hold_done && stall_phase) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check each result transaction, predict each tick transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result with none expected", 8'h0, 8'h0);
        end else begin
          want = results_due.pop_front();
          if (out_if.payload.scl_drive_low !== want.scl_drive_low)
            flag_mismatch("scl_drive_low", 8'(out_if.payload.scl_drive_low),
                          8'(want.scl_drive_low));
          if (out_if.payload.sda_drive_low !== want.sda_drive_low)
            flag_mismatch("sda_drive_low", 8'(out_if.payload.sda_drive_low),
                          8'(want.sda_drive_low));
          if (out_if.payload.busy_res !== want.busy_res)
            flag_mismatch("busy_res", 8'(out_if.payload.busy_res), 8'(want.busy_res));
          if (out_if.payload.read_valid !== want.read_valid)
            flag_mismatch("read_valid", 8'(out_if.payload.read_valid), 8'(want.read_valid));
          if (out_if.payload.read_byte !== want.read_byte)
            flag_mismatch("read_byte", out_if.payload.read_byte, want.read_byte);
          if (out_if.payload.last_byte !== want.last_byte)
            flag_mismatch("last_byte", 8'(out_if.payload.last_byte), 8'(want.last_byte));
          if (out_if.payload.nack_seen !== want.nack_seen)
            flag_mismatch("nack_seen", 8'(out_if.payload.nack_seen), 8'(want.nack_seen));
        end
        results_seen++;
      end
      if (in_if.valid && in_if.ready) begin
        master_tick(pred_state, in_if.payload, want_new);
        results_due.push_back(want_new);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    plan_state = MODEL_RST;
    pred_state = MODEL_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, field extremes, zero count, two-byte read
    set_profile(19, 88, 20, 0, 1'b0);
    push_tick(1'b0, 8'hFF, 8'hFF, 1'b0, 1'b0);
    push_tick(1'b0, 8'h00, 8'h00, 1'b1, 1'b1);
    queue_read(8'h00, 8'd0, n);
    queue_idle(2);
    queue_read(8'hFF, 8'd2, n);
    wait_drained();

    // zero stretch limit, address zero, writes past the register list
    write_reg(CFG_DEVICE_ADDRESS, 17'd0);
    write_reg(CFG_STRETCH_LIMIT, 17'd0);
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, '1);
    run_random(19, 88, 50, 0, 1'b0);

    // top address with extra data bits set, one-tick stretch limit
    write_reg(CFG_DEVICE_ADDRESS, 17'h1FFFF);
    write_reg(CFG_STRETCH_LIMIT, 17'd1);
    run_random(88, 19, 40, 10, 1'b0);

    // short limit with bursts of held-low SCL: stretch timeouts
    write_reg(CFG_DEVICE_ADDRESS, 17'($urandom_range(127)));
    write_reg(CFG_STRETCH_LIMIT, 17'($urandom_range(20, 2)));
    run_random(88, 19, 30, 8, 1'b0);

    // all-ones limit; output held off while ticks keep coming
    write_reg(CFG_DEVICE_ADDRESS, 17'($urandom_range(127)));
    write_reg(CFG_STRETCH_LIMIT, 17'h1FFFF);
    run_random(0, 0, 10, 0, 1'b1);

    // back to reset values, no idling
    write_reg(CFG_DEVICE_ADDRESS, 17'(DEVICE_ADDRESS_RST));
    write_reg(CFG_STRETCH_LIMIT, STRETCH_LIMIT_RST);
    run_random(0, 0, 20, 0, 1'b0);

    if (mismatches == 0) begin
      $display("** i2c_register_read_master_top: PASSED **");
    end else begin
      $display("** i2c_register_read_master_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still due", results_due.size());
    $display("** i2c_register_read_master_top: FAILED **");
    $finish;
  end

endmodule

>>> i2c_register_read_master_top.f
hw/rtl/i2crm_pkg.sv
hw/rtl/i2crm_stream_if.sv
hw/rtl/i2crm_core.sv
hw/rtl/i2crm_out_buf.sv
hw/rtl/i2c_register_read_master_top.sv
hw/rtl/i2crm_checker.sv
dv/tb_top.sv
